FILE: sv/rdsm_pkg.sv
package rdsm_pkg;

  localparam int MAX_PATTERN_DEF = 16;

  localparam logic [7:0] WILDCARD_BYTE = 8'd46;
  localparam logic [7:0] STAR_BYTE     = 8'd42;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] char_value;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  // one decoded operation, valid only in the cycle it is carried out
  typedef struct packed {
    logic       clr;
    logic       app;
    logic       txt;
    logic       fin;
    logic [7:0] ch;
  } ctrl_t;

endpackage

FILE: sv/regex_dot_star_matcher.sv
// channel | ports                          | moves
// --------+--------------------------------+------------------------------------
// input   | in_valid, in_ready, in_data    | one command with its byte per transfer
// result  | out_valid, out_ready, out_data | one match verdict per end command
//
// one item per cycle while no end command is held back: an input register feeds the
// pattern store and the position-set update, whose closure is a single carry chain;
// an end command's verdict is written to the result register when it leaves the input register.
// reset (rst_n low, synchronous) empties the pattern and both registers.
// only an end command waits on a full result register; other commands flow past it.
module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  in_t                         stg_r;
  logic                        stg_valid_r, stg_valid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_t                        out_r;
  logic                        go;
  ctrl_t                       ctrl;
  out_t                        result;
  logic [MAX_PATTERN-1:0][7:0] elem_bytes;
  logic [MAX_PATTERN-1:0]      elem_star;
  logic [MAX_PATTERN-1:0]      elem_live;
  logic [CNT_W-1:0]            elem_count;
  logic                        overflow;

  assign go       = stg_valid_r && (stg_r.cmd != CMD_END || !out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || go;

  always_comb begin
    ctrl     = '0;
    ctrl.ch  = stg_r.char_value;
    case (stg_r.cmd)
      CMD_CLEAR:  ctrl.clr = go;
      CMD_APPEND: ctrl.app = go;
      CMD_TEXT:   ctrl.txt = go;
      CMD_END:    ctrl.fin = go;
      default:    ctrl.clr = 1'b0;
    endcase
  end

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end else if (go) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctrl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_data;
    end
    if (ctrl.fin) begin
      out_r <= result;
    end
  end

  rdsm_pattern #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_pattern (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .elem_bytes (elem_bytes),
    .elem_star  (elem_star),
    .elem_live  (elem_live),
    .elem_count (elem_count),
    .overflow   (overflow)
  );

  rdsm_nfa #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_nfa (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .elem_bytes (elem_bytes),
    .elem_star  (elem_star),
    .elem_live  (elem_live),
    .elem_count (elem_count),
    .overflow   (overflow),
    .result     (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.matched && out_r.pattern_overflow))
    else $error("match reported with pattern overflow");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fin |=> out_valid_r)
    else $error("end command left no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && stg_r.cmd == CMD_END))
    else $error("input stalled without a blocked end command");

  a_ovf_count_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow |-> (elem_count == CNT_W'(MAX_PATTERN)))
    else $error("overflow flagged before pattern full");
`endif

endmodule

FILE: sv/rdsm_pattern.sv
module rdsm_pattern
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctrl_t                       ctrl,
  output logic [MAX_PATTERN-1:0][7:0] elem_bytes,
  output logic [MAX_PATTERN-1:0]      elem_star,
  output logic [MAX_PATTERN-1:0]      elem_live,
  output logic [CNT_W-1:0]            elem_count,
  output logic                        overflow
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][7:0] bytes_r;
  logic [MAX_PATTERN-1:0]      star_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        last_star_r, last_star_nxt;
  logic                        wr_en, star_en;
  logic [CNT_W-1:0]            cnt_m1;
  logic [IDX_W-1:0]            wr_idx, star_idx;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign wr_idx   = count_r[IDX_W-1:0];
  assign star_idx = cnt_m1[IDX_W-1:0];

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_star_nxt = last_star_r;
    wr_en         = 1'b0;
    star_en       = 1'b0;
    if (ctrl.clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (ctrl.app) begin
      if (ctrl.ch == STAR_BYTE && count_r != '0 && !last_star_r) begin
        star_en       = 1'b1;
        last_star_nxt = 1'b1;
      end else if (count_r >= CNT_W'(MAX_PATTERN)) begin
        ovf_nxt = 1'b1;
      end else begin
        wr_en         = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
        last_star_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_star_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      last_star_r <= last_star_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_idx] <= ctrl.ch;
      star_r[wr_idx]  <= 1'b0;
    end
    if (star_en) begin
      star_r[star_idx] <= 1'b1;
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_live
    assign elem_live[k] = (CNT_W'(k) < count_r);
  end

  assign elem_bytes = bytes_r;
  assign elem_star  = star_r;
  assign elem_count = count_r;
  assign overflow   = ovf_r;

endmodule

FILE: sv/rdsm_nfa.sv
module rdsm_nfa
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctrl_t                       ctrl,
  input  logic [MAX_PATTERN-1:0][7:0] elem_bytes,
  input  logic [MAX_PATTERN-1:0]      elem_star,
  input  logic [MAX_PATTERN-1:0]      elem_live,
  input  logic [CNT_W-1:0]            elem_count,
  input  logic                        overflow,
  output out_t                        result
);

  localparam int NPOS = MAX_PATTERN + 1;

  logic [NPOS-1:0]        act_r, act_nxt;
  logic [NPOS-1:0]        prop, seed_run, run_sum, closed, step;
  logic [MAX_PATTERN-1:0] hit;

  // epsilon closure: a set bit runs upward through starred elements, done as a carry chain
  assign prop     = {elem_star & elem_live, 1'b0};
  assign seed_run = prop | act_r;
  assign run_sum  = seed_run + act_r;
  assign closed   = act_r | (seed_run & (run_sum ^ seed_run));

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_hit
    assign hit[k] = closed[k] & elem_live[k] &
                    (elem_bytes[k] == WILDCARD_BYTE || elem_bytes[k] == ctrl.ch);
  end

  assign step = {1'b0, hit & elem_star} | {hit & ~elem_star, 1'b0};

  always_comb begin
    act_nxt = act_r;
    if (ctrl.clr || ctrl.app || ctrl.fin) begin
      act_nxt = NPOS'(1);
    end else if (ctrl.txt) begin
      act_nxt = step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= NPOS'(1);
    end else begin
      act_r <= act_nxt;
    end
  end

  assign result.matched          = closed[elem_count] & ~overflow;
  assign result.pattern_overflow = overflow;

endmodule

FILE: dv/regex_dot_star_matcher_tb.sv
`timescale 1ns / 100ps

module regex_dot_star_matcher_tb;
  import rdsm_pkg::*;

  localparam int          MAXP          = MAX_PATTERN_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int          N_ROWS        = 26;

  typedef struct packed {
    in_t        item;
    logic [4:0] reps;
    logic       pinned;
    out_t       verdict;
  } stim_row_t;

  typedef struct packed {
    logic pinned;
    out_t verdict;
  } pin_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  regex_dot_star_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pattern elements and active position set of the predictor
  logic [7:0]  elem_byte_r [MAXP];
  bit          elem_star_r [MAXP];
  int unsigned elem_count;
  logic [MAXP:0] live_set;
  bit          overflow_r;

  out_t        verdicts_due [$];
  pin_t        pinned_q [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  bit          steady       = 1'b0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{'{CMD_END,    8'h00},         5'd1,  1'b1, '{1'b1, 1'b0}},
    '{'{CMD_TEXT,   8'hff},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_END,    8'hff},         5'd1,  1'b1, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, 8'h61},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, WILDCARD_BYTE}, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, 8'h00},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   8'h61},         5'd2,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   8'hff},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   8'h00},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_END,    8'h00},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, 8'hff},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_END,    8'haa},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_CLEAR,  8'hff},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, WILDCARD_BYTE}, 5'd16, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, 8'h71},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_APPEND, STAR_BYTE},     5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEXT,   8'h7a},         5'd2,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_END,    8'h00},         5'd1,  1'b1, '{1'b0, 1'b1}},
    '{'{CMD_CLEAR,  8'h00},         5'd1,  1'b0, '{1'b0, 1'b0}},
    '{'{CMD_END,    8'h55},         5'd1,  1'b1, '{1'b1, 1'b0}}
  };

  function automatic logic [MAXP:0] skip_starred(logic [MAXP:0] s);
    for (int k = 0; k < elem_count; k++) begin
      if (s[k] && elem_star_r[k]) s[k+1] = 1'b1;
    end
    return s;
  endfunction

  function automatic void step_matcher(input in_t x, output bit emits, output out_t verdict);
    logic [MAXP:0] cur;
    logic [MAXP:0] nxt;
    emits   = 1'b0;
    verdict = '0;
    case (x.cmd)
      CMD_CLEAR: begin
        elem_count = 0;
        overflow_r = 1'b0;
        live_set   = 1;
      end
      CMD_APPEND: begin
        live_set = 1;
        if (x.char_value == STAR_BYTE && elem_count > 0 && !elem_star_r[elem_count-1]) begin
          elem_star_r[elem_count-1] = 1'b1;
        end else if (elem_count >= MAXP) begin
          overflow_r = 1'b1;
        end else begin
          elem_byte_r[elem_count] = x.char_value;
          elem_star_r[elem_count] = 1'b0;
          elem_count++;
        end
      end
      CMD_TEXT: begin
        cur = skip_starred(live_set);
        nxt = '0;
        for (int k = 0; k < elem_count; k++) begin
          if (cur[k] && (elem_byte_r[k] == WILDCARD_BYTE || elem_byte_r[k] == x.char_value)) begin
            if (elem_star_r[k]) nxt[k] = 1'b1;
            else nxt[k+1] = 1'b1;
          end
        end
        live_set = nxt;
      end
      default: begin
        cur   = skip_starred(live_set);
        emits = 1'b1;
        verdict.matched          = cur[elem_count] && !overflow_r;
        verdict.pattern_overflow = overflow_r;
        live_set = 1;
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic got, logic want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %0b want %0b at cycle %0d", what, got, want, cycle_count);
  endtask

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic in_t make_item(cmd_t c, logic [7:0] ch);
    in_t x;
    x.cmd        = c;
    x.char_value = ch;
    return x;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 8'h61;
    if (roll < 6) return 8'h62;
    if (roll < 8) return WILDCARD_BYTE;
    if (roll < 9) return STAR_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(in_t x, logic pinned = 1'b0, out_t verdict = '0);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_q.push_back('{pinned, verdict});
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold the sender until every due verdict is in
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic play_directed();
    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].verdict);
    end
  endtask

  task automatic play_random();
    logic [7:0]  pat_bytes [$];
    bit          pat_stars [$];
    logic [7:0]  text [$];
    int unsigned goal;
    int unsigned n_elem;
    int unsigned reps;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 6))
          send_item(make_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      end else begin
        pat_bytes.delete();
        pat_stars.delete();
        send_item(make_item(CMD_CLEAR, 8'($urandom_range(0, 255))));
        n_elem = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 6);
        for (int i = 0; i < n_elem; i++) begin
          pat_bytes.push_back(pick_byte());
          pat_stars.push_back($urandom_range(0, 2) == 0);
          send_item(make_item(CMD_APPEND, pat_bytes[i]));
          if (pat_stars[i]) send_item(make_item(CMD_APPEND, STAR_BYTE));
        end
        repeat ($urandom_range(1, 4)) begin
          text.delete();
          if ($urandom_range(0, 3) != 0) begin
            foreach (pat_bytes[i]) begin
              reps = pat_stars[i] ? $urandom_range(0, 3) : 1;
              repeat (reps)
                text.push_back(pat_bytes[i] == WILDCARD_BYTE ?
                               8'($urandom_range(0, 255)) : pat_bytes[i]);
            end
            if ($urandom_range(0, 5) == 0 && text.size() != 0)
              text[$urandom_range(0, text.size() - 1)] = pick_byte();
          end else begin
            repeat ($urandom_range(0, 6)) text.push_back(pick_byte());
          end
          foreach (text[i]) send_item(make_item(CMD_TEXT, text[i]));
          // pattern byte in the middle of a text
          if ($urandom_range(0, 15) == 0) send_item(make_item(CMD_APPEND, pick_byte()));
          send_item(make_item(CMD_END, 8'($urandom_range(0, 255))));
        end
      end
      if ($urandom_range(0, 24) == 0) settle();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    out_t pred;
    pin_t pin;
    bit   emits;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("verdict with none due", out_data.matched, 1'b0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.matched !== want.matched)
            flag_mismatch("matched", out_data.matched, want.matched);
          if (out_data.pattern_overflow !== want.pattern_overflow)
            flag_mismatch("pattern_overflow", out_data.pattern_overflow, want.pattern_overflow);
        end
      end
      if (in_valid && in_ready) begin
        pin = pinned_q.pop_front();
        step_matcher(in_data, emits, pred);
        if (emits) verdicts_due.push_back(pin.pinned ? pin.verdict : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[regex_dot_star_matcher] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    elem_count = 0;
    live_set   = 1;
    overflow_r = 1'b0;
    foreach (elem_byte_r[i]) begin
      elem_byte_r[i] = '0;
      elem_star_r[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    play_directed();
    settle();
    play_random();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("[regex_dot_star_matcher] OK");
    end else begin
      $display("[regex_dot_star_matcher] ERROR");
    end
    $finish;
  end

endmodule
